// ----- rtl/bba_pkg.sv -----
`timescale 1ns / 1ps

package bba_pkg;

  // block count fixed by the port widths
  localparam int MAX_BLOCKS    = 512;
  localparam int WORD_BITS_DEF = 32;

  localparam int FUNC_W   = 2;
  localparam int LEN_W    = 10;
  localparam int IDX_W    = 9;
  localparam int STATUS_W = 2;
  localparam int CNT_W    = $clog2(MAX_BLOCKS + 1);
  localparam int TOTAL_W  = 10;

  localparam int IN_TDATA_W  = 24;
  localparam int IN_PAD_W    = IN_TDATA_W - LEN_W - IDX_W;
  localparam int OUT_TDATA_W = 24;
  localparam int OUT_PAD_W   = OUT_TDATA_W - IDX_W - 1 - CNT_W;

  typedef enum logic [FUNC_W-1:0] {
    FN_ALLOC = 2'd0,
    FN_FREE  = 2'd1,
    FN_TEST  = 2'd2,
    FN_CLEAR = 2'd3
  } func_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 2'd0,
    ST_NOSPACE  = 2'd1,
    ST_BADINDEX = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_FIND,
    S_LOOK,
    S_SCAN,
    S_MARK,
    S_RESP
  } state_e;

endpackage

// ----- rtl/bba_map_mem.sv -----
`timescale 1ns / 1ps

module bba_map_mem #(
  parameter int WORD_BITS = bba_pkg::WORD_BITS_DEF,
  parameter int MAP_WORDS = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         clr_i,
  input  logic                         rd_en_i,
  input  logic [$clog2(MAP_WORDS)-1:0] rd_addr_i,
  output logic [WORD_BITS-1:0]         rd_data_o,
  input  logic                         wr_en_i,
  input  logic [$clog2(MAP_WORDS)-1:0] wr_addr_i,
  input  logic [WORD_BITS-1:0]         wr_data_i
);

  logic [WORD_BITS-1:0] mem [MAP_WORDS];
  logic [MAP_WORDS-1:0] vld_q;
  logic [WORD_BITS-1:0] rdata_q;
  logic                 rd_vld_q;

  // row valid bits: a row never written since the last clear reads as free
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (clr_i) begin
        vld_q <= '0;
      end else if (wr_en_i) begin
        vld_q[wr_addr_i] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_vld_q <= vld_q[rd_addr_i];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rdata_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_vld_q ? rdata_q : '0;

endmodule

// ----- rtl/bba_run_find.sv -----
`timescale 1ns / 1ps

module bba_run_find #(
  parameter int WORD_BITS = bba_pkg::WORD_BITS_DEF,
  parameter int POS_W     = 10
) (
  input  logic [WORD_BITS-1:0]         word_i,
  input  logic [POS_W-1:0]             base_i,
  input  logic [bba_pkg::CNT_W-1:0]    run_i,
  input  logic [bba_pkg::LEN_W-1:0]    len_i,
  input  logic [bba_pkg::CNT_W-1:0]    total_i,
  output logic                         hit_o,
  output logic [$clog2(WORD_BITS)-1:0] hit_off_o,
  output logic [bba_pkg::CNT_W-1:0]    run_o
);

  localparam int BO_W  = $clog2(WORD_BITS);
  localparam int SUM_W = ((POS_W > bba_pkg::CNT_W) ? POS_W : bba_pkg::CNT_W) + 2;

  logic [WORD_BITS-1:0] usable;
  logic [WORD_BITS-1:0] win_ok;
  logic [WORD_BITS-1:0] hit_vec;
  logic [BO_W-1:0]      last_used;
  logic                 any_used;

  // a block is usable when free and below the total
  always_comb begin
    for (int k = 0; k < WORD_BITS; k++) begin
      usable[k] = !word_i[k] &&
                  ((SUM_W'(base_i) + SUM_W'(k)) < SUM_W'(total_i));
    end
  end

  // run ending at bit k reaches len: the last len bits (within this word) are usable
  // and, where the window reaches below bit 0, the carried run makes up the rest
  always_comb begin
    for (int k = 0; k < WORD_BITS; k++) begin
      win_ok[k] = 1'b1;
      for (int j = 0; j <= k; j++) begin
        if (len_i > bba_pkg::LEN_W'(k - j)) begin
          win_ok[k] = win_ok[k] & usable[j];
        end
      end
      hit_vec[k] = win_ok[k] &&
                   ((SUM_W'(run_i) + SUM_W'(k + 1)) >= SUM_W'(len_i));
    end
  end

  always_comb begin
    hit_off_o = '0;
    for (int k = WORD_BITS - 1; k >= 0; k--) begin
      if (hit_vec[k]) begin
        hit_off_o = BO_W'(k);
      end
    end
  end

  always_comb begin
    last_used = '0;
    any_used  = 1'b0;
    for (int k = 0; k < WORD_BITS; k++) begin
      if (!usable[k]) begin
        last_used = BO_W'(k);
        any_used  = 1'b1;
      end
    end
  end

  assign hit_o = |hit_vec;
  assign run_o = any_used ?
                 (bba_pkg::CNT_W'(WORD_BITS - 1) - bba_pkg::CNT_W'(last_used)) :
                 (run_i + bba_pkg::CNT_W'(WORD_BITS));

endmodule

// ----- rtl/bitmap_block_allocator.sv -----
`timescale 1ns / 1ps
// first-fit contiguous block allocator, path from request transfer to result valid:
// clear, rejected and zero-length requests go straight to the response step, free/test step
// to the map word holding the block, read it, then respond; allocate scans words upward (one
// map word read per cycle), marks the lower words of a found run downward, then responds
// flow: one request at a time, the next accepted once the result is staged; a held result stalls
// reset: map reads all free at once (row valid bits), total and free count 512

module bitmap_block_allocator #(
  parameter int WORD_BITS = bba_pkg::WORD_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,

  // configuration write: total block count
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [bba_pkg::TOTAL_W-1:0]       cfg_data_i,

  // request stream
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [bba_pkg::IN_TDATA_W-1:0]    s_axis_tdata,  // run_length, block_index, pad
  input  logic [bba_pkg::FUNC_W-1:0]        s_axis_tuser,  // func

  // result stream
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [bba_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,  // start_block, block_used,
                                                           // free_count, pad
  output logic [bba_pkg::STATUS_W-1:0]      m_axis_tuser   // status
);

  localparam int MAP_WORDS = (bba_pkg::MAX_BLOCKS + WORD_BITS - 1) / WORD_BITS;
  localparam int WA_W      = $clog2(MAP_WORDS);
  localparam int BO_W      = $clog2(WORD_BITS);
  localparam int POS_W     = $clog2(MAP_WORDS * WORD_BITS + 1);
  localparam int CNT_W     = bba_pkg::CNT_W;
  localparam int LEN_W     = bba_pkg::LEN_W;
  localparam int IDX_W     = bba_pkg::IDX_W;
  localparam int SUM_W     = ((POS_W > LEN_W) ? POS_W : LEN_W) + 2;

  // sequencer state
  bba_pkg::state_e  state_q, state_d;
  bba_pkg::func_e   op_q, op_d;
  logic [LEN_W-1:0] len_q, len_d;
  logic [IDX_W-1:0] idx_q, idx_d;
  logic [WA_W-1:0]  cw_q, cw_d;       // current map word
  logic [POS_W-1:0] cb_q, cb_d;       // block number of its bit 0
  logic [CNT_W-1:0] run_q, run_d;     // free run carried in from lower words
  logic [BO_W-1:0]  off_q, off_d;
  logic [POS_W-1:0] start_q, start_d;
  logic [POS_W-1:0] end_q, end_d;
  logic [CNT_W-1:0] free_q, free_d;
  logic [CNT_W-1:0] total_q;

  // staged result
  bba_pkg::status_e res_status_q, res_status_d;
  logic [IDX_W-1:0] res_start_q, res_start_d;
  logic             res_used_q, res_used_d;

  // output register
  logic             out_valid_q;
  bba_pkg::status_e out_status_q;
  logic [IDX_W-1:0] out_start_q;
  logic             out_used_q;
  logic [CNT_W-1:0] out_free_q;
  logic             out_load;

  // map memory port
  logic                 mem_clr;
  logic                 mem_rd_en;
  logic [WA_W-1:0]      mem_rd_addr;
  logic [WORD_BITS-1:0] mem_rd_data;
  logic                 mem_wr_en;
  logic [WA_W-1:0]      mem_wr_addr;
  logic [WORD_BITS-1:0] mem_wr_data;

  // run search on the word just read
  logic                 hit;
  logic [BO_W-1:0]      hit_off;
  logic [CNT_W-1:0]     run_next;
  logic [POS_W-1:0]     scan_end;
  logic [POS_W-1:0]     scan_start;
  logic [POS_W-1:0]     mk_start;
  logic [POS_W-1:0]     mk_end;
  logic [WORD_BITS-1:0] mark_mask;

  logic                 in_xfer;
  logic                 cfg_xfer;
  logic [CNT_W-1:0]     cfg_total;
  logic [LEN_W-1:0]     in_len;
  logic [IDX_W-1:0]     in_idx;
  bba_pkg::func_e       in_func;

  assign in_len  = s_axis_tdata[LEN_W-1:0];
  assign in_idx  = s_axis_tdata[LEN_W +: IDX_W];
  assign in_func = bba_pkg::func_e'(s_axis_tuser);

  // configuration has priority over a request in the same cycle
  assign cfg_ready_o   = (state_q == bba_pkg::S_IDLE);
  assign s_axis_tready = (state_q == bba_pkg::S_IDLE) && !cfg_valid_i;
  assign cfg_xfer      = cfg_valid_i && cfg_ready_o;
  assign in_xfer       = s_axis_tvalid && s_axis_tready;

  // totals above the map size saturate
  assign cfg_total = (CNT_W'(cfg_data_i) > CNT_W'(bba_pkg::MAX_BLOCKS)) ?
                     CNT_W'(bba_pkg::MAX_BLOCKS) : CNT_W'(cfg_data_i);

  bba_map_mem #(
    .WORD_BITS (WORD_BITS),
    .MAP_WORDS (MAP_WORDS)
  ) u_map (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .clr_i     (mem_clr),
    .rd_en_i   (mem_rd_en),
    .rd_addr_i (mem_rd_addr),
    .rd_data_o (mem_rd_data),
    .wr_en_i   (mem_wr_en),
    .wr_addr_i (mem_wr_addr),
    .wr_data_i (mem_wr_data)
  );

  bba_run_find #(
    .WORD_BITS (WORD_BITS),
    .POS_W     (POS_W)
  ) u_find (
    .word_i    (mem_rd_data),
    .base_i    (cb_q),
    .run_i     (run_q),
    .len_i     (len_q),
    .total_i   (total_q),
    .hit_o     (hit),
    .hit_off_o (hit_off),
    .run_o     (run_next)
  );

  // run found: last block of the run and its first block
  assign scan_end   = cb_q + POS_W'(hit_off);
  assign scan_start = POS_W'(SUM_W'(scan_end) + SUM_W'(1) - SUM_W'(len_q));

  // bits of the current word that fall inside the run being marked
  assign mk_start = (state_q == bba_pkg::S_SCAN) ? scan_start : start_q;
  assign mk_end   = (state_q == bba_pkg::S_SCAN) ? scan_end   : end_q;

  always_comb begin
    for (int k = 0; k < WORD_BITS; k++) begin
      mark_mask[k] = ((SUM_W'(cb_q) + SUM_W'(k)) >= SUM_W'(mk_start)) &&
                     ((SUM_W'(cb_q) + SUM_W'(k)) <= SUM_W'(mk_end));
    end
  end

  always_comb begin
    state_d      = state_q;
    op_d         = op_q;
    len_d        = len_q;
    idx_d        = idx_q;
    cw_d         = cw_q;
    cb_d         = cb_q;
    run_d        = run_q;
    off_d        = off_q;
    start_d      = start_q;
    end_d        = end_q;
    free_d       = free_q;
    res_status_d = res_status_q;
    res_start_d  = res_start_q;
    res_used_d   = res_used_q;
    mem_clr      = 1'b0;
    mem_rd_en    = 1'b0;
    mem_rd_addr  = cw_q;
    mem_wr_en    = 1'b0;
    mem_wr_addr  = cw_q;
    mem_wr_data  = mem_rd_data | mark_mask;
    out_load     = 1'b0;

    case (state_q)
      bba_pkg::S_IDLE: begin
        if (cfg_xfer) begin
          mem_clr = 1'b1;
          free_d  = cfg_total;
        end else if (in_xfer) begin
          op_d         = in_func;
          len_d        = in_len;
          idx_d        = in_idx;
          cw_d         = '0;
          cb_d         = '0;
          run_d        = '0;
          res_status_d = bba_pkg::ST_OK;
          res_start_d  = '0;
          res_used_d   = 1'b0;
          state_d      = bba_pkg::S_RESP;
          case (in_func)
            bba_pkg::FN_ALLOC: begin
              if (free_q == '0) begin
                res_status_d = bba_pkg::ST_NOSPACE;
              end else if (in_len != '0) begin
                mem_rd_en   = 1'b1;
                mem_rd_addr = '0;
                state_d     = bba_pkg::S_SCAN;
              end
            end
            bba_pkg::FN_FREE, bba_pkg::FN_TEST: begin
              if (CNT_W'(in_idx) >= total_q) begin
                res_status_d = bba_pkg::ST_BADINDEX;
              end else begin
                state_d = bba_pkg::S_FIND;
              end
            end
            default: begin
              // clear all
              mem_clr = 1'b1;
              free_d  = total_q;
            end
          endcase
        end
      end

      // step to the word holding the addressed block
      bba_pkg::S_FIND: begin
        if (SUM_W'(idx_q) < (SUM_W'(cb_q) + SUM_W'(WORD_BITS))) begin
          mem_rd_en = 1'b1;
          off_d     = BO_W'(SUM_W'(idx_q) - SUM_W'(cb_q));
          state_d   = bba_pkg::S_LOOK;
        end else begin
          cw_d = cw_q + WA_W'(1);
          cb_d = cb_q + POS_W'(WORD_BITS);
        end
      end

      bba_pkg::S_LOOK: begin
        if (op_q == bba_pkg::FN_TEST) begin
          res_used_d = mem_rd_data[off_q];
        end else if (mem_rd_data[off_q]) begin
          mem_wr_en               = 1'b1;
          mem_wr_data             = mem_rd_data;
          mem_wr_data[off_q]      = 1'b0;
          free_d                  = free_q + CNT_W'(1);
        end
        state_d = bba_pkg::S_RESP;
      end

      bba_pkg::S_SCAN: begin
        if (hit) begin
          mem_wr_en   = 1'b1;
          start_d     = scan_start;
          end_d       = scan_end;
          free_d      = free_q - CNT_W'(len_q);
          res_start_d = IDX_W'(scan_start);
          if (scan_start >= cb_q) begin
            state_d = bba_pkg::S_RESP;
          end else begin
            mem_rd_en   = 1'b1;
            mem_rd_addr = cw_q - WA_W'(1);
            cw_d        = cw_q - WA_W'(1);
            cb_d        = cb_q - POS_W'(WORD_BITS);
            state_d     = bba_pkg::S_MARK;
          end
        end else if (((SUM_W'(cb_q) + SUM_W'(WORD_BITS)) >= SUM_W'(total_q)) ||
                     (cw_q == WA_W'(MAP_WORDS - 1))) begin
          res_status_d = bba_pkg::ST_NOSPACE;
          state_d      = bba_pkg::S_RESP;
        end else begin
          mem_rd_en   = 1'b1;
          mem_rd_addr = cw_q + WA_W'(1);
          cw_d        = cw_q + WA_W'(1);
          cb_d        = cb_q + POS_W'(WORD_BITS);
          run_d       = run_next;
        end
      end

      // walk back down over the lower words of the run, one per cycle
      bba_pkg::S_MARK: begin
        mem_wr_en = 1'b1;
        if (start_q >= cb_q) begin
          state_d = bba_pkg::S_RESP;
        end else begin
          mem_rd_en   = 1'b1;
          mem_rd_addr = cw_q - WA_W'(1);
          cw_d        = cw_q - WA_W'(1);
          cb_d        = cb_q - POS_W'(WORD_BITS);
        end
      end

      bba_pkg::S_RESP: begin
        if (!out_valid_q || m_axis_tready) begin
          out_load = 1'b1;
          state_d  = bba_pkg::S_IDLE;
        end
      end

      default: begin
        state_d = bba_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= bba_pkg::S_IDLE;
      free_q      <= CNT_W'(bba_pkg::MAX_BLOCKS);
      total_q     <= CNT_W'(bba_pkg::MAX_BLOCKS);
      cw_q        <= '0;
      cb_q        <= '0;
      run_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      free_q  <= free_d;
      cw_q    <= cw_d;
      cb_q    <= cb_d;
      run_q   <= run_d;
      if (cfg_xfer) begin
        total_q <= cfg_total;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    op_q         <= op_d;
    len_q        <= len_d;
    idx_q        <= idx_d;
    off_q        <= off_d;
    start_q      <= start_d;
    end_q        <= end_d;
    res_status_q <= res_status_d;
    res_start_q  <= res_start_d;
    res_used_q   <= res_used_d;
    if (out_load) begin
      out_status_q <= res_status_q;
      out_start_q  <= res_start_q;
      out_used_q   <= res_used_q;
      out_free_q   <= free_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_status_q;
  assign m_axis_tdata  = {{bba_pkg::OUT_PAD_W{1'b0}}, out_free_q, out_used_q, out_start_q};

  // free count can never pass the managed total
  a_free_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    free_q <= total_q)
    else $error("free count above total");

  // map is written only while a request is being worked on
  a_wr_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_wr_en |-> (state_q == bba_pkg::S_LOOK || state_q == bba_pkg::S_SCAN ||
                   state_q == bba_pkg::S_MARK))
    else $error("map write outside lookup, scan or mark");

  // a new result appears only after the response step
  a_out_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == bba_pkg::S_RESP))
    else $error("result without response step");

  // marking never runs below the first block of the run
  a_mark_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == bba_pkg::S_MARK) |->
      (SUM_W'(start_q) < (SUM_W'(cb_q) + SUM_W'(WORD_BITS))))
    else $error("mark pass below run start");

endmodule

// ----- verif/bitmap_block_allocator_tb.sv -----
`timescale 1ns / 1ps

module bitmap_block_allocator_tb;

  localparam int CYCLE_LIMIT   = 200000;
  // quiet stretch after a drain before the next phase starts
  localparam int SETTLE_CYCLES = 48;
  localparam int RANDOM_PHASE  = 55;

  typedef struct {
    bba_pkg::func_e            fn;
    logic [bba_pkg::LEN_W-1:0] len;
    logic [bba_pkg::IDX_W-1:0] idx;
  } request_t;

  typedef struct {
    bba_pkg::status_e          status;
    logic [bba_pkg::IDX_W-1:0] start;
    logic                      used;
    logic [bba_pkg::CNT_W-1:0] free_cnt;
  } result_t;

  logic                            clk_i         = 1'b0;
  logic                            rst_ni        = 1'b0;
  logic                            cfg_valid_i   = 1'b0;
  logic                            cfg_ready_o;
  logic [bba_pkg::TOTAL_W-1:0]     cfg_data_i    = '0;
  logic                            s_axis_tvalid = 1'b0;
  logic                            s_axis_tready;
  logic [bba_pkg::IN_TDATA_W-1:0]  s_axis_tdata  = '0;  // run_length, block_index, pad
  logic [bba_pkg::FUNC_W-1:0]      s_axis_tuser  = '0;  // func
  logic                            m_axis_tvalid;
  logic                            m_axis_tready = 1'b0;
  logic [bba_pkg::OUT_TDATA_W-1:0] m_axis_tdata;  // start_block, block_used, free_count, pad
  logic [bba_pkg::STATUS_W-1:0]    m_axis_tuser;  // status

  // predicted allocator state
  logic [bba_pkg::MAX_BLOCKS-1:0]  used_bits;
  logic [bba_pkg::TOTAL_W-1:0]     total_reg;
  int unsigned                     free_blocks;

  request_t    request_q[$];
  result_t     want_results[$];
  request_t    offered;
  int unsigned phase_limit;
  int          send_gap     = 0;
  int          sink_stall   = 0;
  bit          idle_on      = 1'b1;
  int          mismatches   = 0;
  int          results_seen = 0;
  int          cycle_cnt    = 0;

  bitmap_block_allocator u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_cnt);
      $display("FAILED: results differ");
      $finish;
    end
  end

  task automatic note_mismatch(input string msg);
    mismatches++;
    $display("mismatch: %s", msg);
  endtask

  // blocks beyond the map size are not managed
  function automatic int unsigned managed_blocks();
    return (total_reg > bba_pkg::MAX_BLOCKS) ? bba_pkg::MAX_BLOCKS : total_reg;
  endfunction

  task automatic clear_map();
    used_bits   = '0;
    free_blocks = managed_blocks();
  endtask

  // first-fit allocator prediction for one accepted request
  task automatic predict_request(input request_t rq);
    result_t     r;
    int unsigned lim, run, first;
    bit          found;
    lim      = managed_blocks();
    r.status = bba_pkg::ST_OK;
    r.start  = '0;
    r.used   = 1'b0;
    run      = 0;
    first    = 0;
    found    = 1'b0;
    case (rq.fn)
      bba_pkg::FN_ALLOC: begin
        if (free_blocks == 0) begin
          r.status = bba_pkg::ST_NOSPACE;
        end else if (rq.len != 0) begin
          for (int i = 0; i < lim && !found; i++) begin
            run = used_bits[i] ? 0 : run + 1;
            if (run == rq.len) begin
              found = 1'b1;
              first = i + 1 - rq.len;
            end
          end
          if (found) begin
            for (int i = first; i < first + rq.len; i++) begin
              used_bits[i] = 1'b1;
              if (free_blocks > 0) free_blocks--;
            end
            r.start = bba_pkg::IDX_W'(first);
          end else begin
            r.status = bba_pkg::ST_NOSPACE;
          end
        end
      end
      bba_pkg::FN_FREE: begin
        if (rq.idx >= lim) begin
          r.status = bba_pkg::ST_BADINDEX;
        end else if (used_bits[rq.idx]) begin
          used_bits[rq.idx] = 1'b0;
          if (free_blocks < lim) free_blocks++;
        end
      end
      bba_pkg::FN_TEST: begin
        if (rq.idx >= lim) r.status = bba_pkg::ST_BADINDEX;
        else r.used = used_bits[rq.idx];
      end
      default: clear_map();
    endcase
    r.free_cnt = bba_pkg::CNT_W'(free_blocks);
    want_results.push_back(r);
  endtask

  // request driver: one transfer per handshake, random gaps after some
  always @(posedge clk_i) begin : drive_requests
    logic next_valid;
    next_valid = s_axis_tvalid;
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        predict_request(offered);
        next_valid = 1'b0;
        if (idle_on && $urandom_range(0, 5) == 0) send_gap = $urandom_range(1, 12);
      end
      if (!next_valid) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (request_q.size() != 0) begin
          offered = request_q.pop_front();
          s_axis_tdata <= {{bba_pkg::IN_PAD_W{1'b0}}, offered.idx, offered.len};
          s_axis_tuser <= offered.fn;
          next_valid = 1'b1;
        end
      end
    end
    s_axis_tvalid <= next_valid;
  end

  // result monitor with random back-pressure bursts
  always @(posedge clk_i) begin : check_results
    result_t w;
    logic    next_ready;
    next_ready = m_axis_tready;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (want_results.size() == 0) begin
          note_mismatch($sformatf("result %0d arrived with nothing expected", results_seen));
        end else begin
          w = want_results.pop_front();
          if (m_axis_tuser !== w.status)
            note_mismatch($sformatf("result %0d status: got %0d want %0d",
                                    results_seen, m_axis_tuser, w.status));
          if (m_axis_tdata[bba_pkg::IDX_W-1:0] !== w.start)
            note_mismatch($sformatf("result %0d start_block: got %0d want %0d",
                                    results_seen, m_axis_tdata[bba_pkg::IDX_W-1:0],
                                    w.start));
          if (m_axis_tdata[bba_pkg::IDX_W] !== w.used)
            note_mismatch($sformatf("result %0d block_used: got %0d want %0d",
                                    results_seen, m_axis_tdata[bba_pkg::IDX_W], w.used));
          if (m_axis_tdata[bba_pkg::IDX_W+1 +: bba_pkg::CNT_W] !== w.free_cnt)
            note_mismatch($sformatf("result %0d free_count: got %0d want %0d",
                                    results_seen,
                                    m_axis_tdata[bba_pkg::IDX_W+1 +: bba_pkg::CNT_W],
                                    w.free_cnt));
        end
        results_seen++;
      end
      if (sink_stall > 0) begin
        sink_stall--;
        next_ready = 1'b0;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
        sink_stall = $urandom_range(0, 11);
        next_ready = 1'b0;
      end else begin
        next_ready = 1'b1;
      end
    end
    m_axis_tready <= next_ready;
  end

  task automatic add_req(input bba_pkg::func_e fn, input int unsigned len,
                         input int unsigned idx);
    request_t rq;
    rq.fn  = fn;
    rq.len = bba_pkg::LEN_W'(len);
    rq.idx = bba_pkg::IDX_W'(idx);
    request_q.push_back(rq);
  endtask

  // sender holds off until every outstanding result has come back
  // (checked mid-cycle so the driver's updates at the edge are already visible)
  task automatic wait_drain();
    do @(negedge clk_i);
    while (request_q.size() != 0 || s_axis_tvalid || want_results.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_total(input logic [bba_pkg::TOTAL_W-1:0] value);
    cfg_data_i  <= value;
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    total_reg   = value;
    clear_map();
    phase_limit = managed_blocks();
    @(posedge clk_i);
  endtask

  // mostly small allocations and frees near the low end, where first fit packs runs
  task automatic queue_random(input int count);
    int unsigned pick, top, len, idx;
    for (int k = 0; k < count; k++) begin
      top  = (phase_limit == 0) ? 0 : phase_limit - 1;
      pick = $urandom_range(0, 9);
      if (pick < 6) len = $urandom_range(1, 6);
      else if (pick < 8) len = $urandom_range(1, 40);
      else if (pick < 9) len = $urandom_range(0, 1023);
      else len = $urandom_range(0, phase_limit);
      pick = $urandom_range(0, 9);
      if (pick < 5) idx = $urandom_range(0, (top < 63) ? top : 63);
      else if (pick < 8) idx = $urandom_range(0, top);
      else idx = $urandom_range(0, 511);
      pick = $urandom_range(0, 99);
      if (pick < 45) add_req(bba_pkg::FN_ALLOC, len, $urandom_range(0, 511));
      else if (pick < 75) add_req(bba_pkg::FN_FREE, $urandom_range(0, 1023), idx);
      else if (pick < 97) add_req(bba_pkg::FN_TEST, $urandom_range(0, 1023), idx);
      else add_req(bba_pkg::FN_CLEAR, $urandom_range(0, 1023), $urandom_range(0, 511));
    end
  endtask

  initial begin : stimulus
    logic [bba_pkg::TOTAL_W-1:0] totals [7];
    totals = '{10'd512, 10'd100, 10'd1023, 10'd7, 10'd513, 10'd300, 10'd512};
    total_reg   = 10'd512;
    clear_map();
    phase_limit = managed_blocks();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // full map after reset: empty runs, full map, fragmented map
    add_req(bba_pkg::FN_TEST, 0, 511);
    add_req(bba_pkg::FN_ALLOC, 0, 0);
    add_req(bba_pkg::FN_ALLOC, 1, 0);
    add_req(bba_pkg::FN_ALLOC, 1023, 0);
    add_req(bba_pkg::FN_ALLOC, 511, 0);
    add_req(bba_pkg::FN_ALLOC, 0, 0);
    add_req(bba_pkg::FN_TEST, 0, 511);
    add_req(bba_pkg::FN_FREE, 0, 511);
    add_req(bba_pkg::FN_FREE, 0, 511);
    add_req(bba_pkg::FN_FREE, 0, 0);
    add_req(bba_pkg::FN_ALLOC, 2, 0);
    add_req(bba_pkg::FN_ALLOC, 1, 0);
    add_req(bba_pkg::FN_CLEAR, 0, 0);
    add_req(bba_pkg::FN_ALLOC, 512, 0);
    add_req(bba_pkg::FN_CLEAR, 0, 0);
    wait_drain();

    // no blocks managed at all
    set_total(10'd0);
    add_req(bba_pkg::FN_ALLOC, 0, 0);
    add_req(bba_pkg::FN_FREE, 0, 0);
    add_req(bba_pkg::FN_TEST, 0, 511);
    add_req(bba_pkg::FN_CLEAR, 0, 0);
    wait_drain();

    // single block: index past the total
    set_total(10'd1);
    add_req(bba_pkg::FN_ALLOC, 1, 0);
    add_req(bba_pkg::FN_TEST, 0, 1);
    add_req(bba_pkg::FN_FREE, 0, 0);
    wait_drain();

    // total above the map size saturates
    set_total(10'd1023);
    add_req(bba_pkg::FN_ALLOC, 512, 0);
    add_req(bba_pkg::FN_TEST, 0, 511);
    wait_drain();

    for (int p = 0; p < 7; p++) begin
      set_total(totals[p]);
      queue_random(RANDOM_PHASE);
      wait_drain();
    end

    set_total(10'($urandom_range(1, 512)));
    queue_random(RANDOM_PHASE / 2);
    wait_drain();

    // closing stretch at full rate on both sides
    idle_on = 1'b0;
    set_total(10'd512);
    queue_random(RANDOM_PHASE);
    wait_drain();

    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/bba_pkg.sv
rtl/bba_map_mem.sv
rtl/bba_run_find.sv
rtl/bitmap_block_allocator.sv
verif/bitmap_block_allocator_tb.sv
